// ----- hw/rtl/nam_pkg.sv -----
package nam_pkg;

    // Field widths fixed by the item formats
    localparam int FUNC_W   = 3;
    localparam int NODE_W   = 6;
    localparam int LINK_W   = 8;
    localparam int AMT_W    = 32;
    localparam int STAT_W   = 3;
    localparam int FC_W     = 7;
    localparam int TOTAL_W  = 32;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKS = 1'b1;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_CLAIM     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADD       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SUB       = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST_FREE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_LIST_USED = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NODE_BUSY = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NODE_IDLE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NEGATIVE  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd5;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NODE_W-1:0] node_index;
        logic [LINK_W-1:0] link_index;
        logic [AMT_W-1:0]  traffic_amount;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FC_W-1:0]    free_count;
        logic [NODE_W-1:0]  listed_node;
        logic               listed_valid;
        logic [TOTAL_W-1:0] link_total;
        logic               last;
    } result_t;

    // Classified operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_CLAIM,
        OP_RELEASE,
        OP_ADD,
        OP_SUB,
        OP_LIST_FREE,
        OP_LIST_USED,
        OP_CLEAR,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] node_index;
        logic [LINK_W-1:0] link_index;
        logic [AMT_W-1:0]  traffic_amount;
    } queue_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRAFFIC,
        ST_LIST,
        ST_LIST_END
    } back_state_t;

endpackage

// ----- hw/rtl/nam_front.sv -----
module nam_front
    import nam_pkg::*;
#(
    parameter int LINK_CNT_W = 9
)
(
    input  logic                  start,
    input  cmd_t                  cmd,
    input  logic [FC_W-1:0]       eff_nodes,
    input  logic [LINK_CNT_W-1:0] eff_links,
    input  logic                  q_full,
    output logic                  busy,
    output logic                  push,
    output queue_entry_t          entry
);

    logic node_ok;
    logic link_ok;

    assign node_ok = FC_W'(cmd.node_index) < eff_nodes;
    assign link_ok = LINK_CNT_W'(cmd.link_index) < eff_links;

    assign busy = q_full;
    assign push = start && !q_full;

    // Classify: range checks are settled here so the back end only executes
    always_comb
    begin
        entry.node_index     = cmd.node_index;
        entry.link_index     = cmd.link_index;
        entry.traffic_amount = cmd.traffic_amount;
        unique case (cmd.func)
            FN_CLAIM:     entry.op = node_ok ? OP_CLAIM : OP_REJECT;
            FN_RELEASE:   entry.op = node_ok ? OP_RELEASE : OP_REJECT;
            FN_ADD:       entry.op = link_ok ? OP_ADD : OP_REJECT;
            FN_SUB:       entry.op = link_ok ? OP_SUB : OP_REJECT;
            FN_LIST_FREE: entry.op = OP_LIST_FREE;
            FN_LIST_USED: entry.op = OP_LIST_USED;
            FN_CLEAR:     entry.op = OP_CLEAR;
            default:      entry.op = OP_REJECT;
        endcase
    end

endmodule

// ----- hw/rtl/nam_queue.sv -----
module nam_queue
    import nam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t din,
    input  logic         pop,
    output queue_entry_t dout,
    output logic         empty,
    output logic         full
);

    queue_entry_t         slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == Q_CNT_W'(Q_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hw/rtl/nam_back.sv -----
module nam_back
    import nam_pkg::*;
#(
    parameter int MAX_NODES    = 64,
    parameter int MAX_LINKS    = 256,
    parameter int TRAFFIC_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  queue_entry_t    q_head,
    output logic            q_pop,
    input  logic [FC_W-1:0] eff_nodes,
    input  logic            cfg_clear,
    input  logic [FC_W-1:0] clear_nodes,
    output logic            done,
    output result_t         result
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LAW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int SW  = ((TRAFFIC_BITS > TOTAL_W) ? TRAFFIC_BITS : TOTAL_W) + 1;
    localparam logic [SW-1:0] TMAX = SW'({TRAFFIC_BITS{1'b1}});

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [MAX_NODES-1:0]     busy_map_reg;
    logic [MAX_NODES-1:0]     busy_map_next;
    logic [FC_W-1:0]          free_reg;
    logic [FC_W-1:0]          free_next;
    logic [MAX_LINKS-1:0]     lvalid_reg;
    logic [MAX_LINKS-1:0]     lvalid_next;
    logic [TRAFFIC_BITS-1:0]  traffic_mem [MAX_LINKS];
    logic [TRAFFIC_BITS-1:0]  rdata_reg;
    logic                     mem_we;
    logic [TRAFFIC_BITS-1:0]  mem_wdata;
    queue_entry_t             item_reg;
    queue_entry_t             item_next;
    logic [NAW-1:0]           scan_reg;
    logic [NAW-1:0]           scan_next;
    logic [NAW-1:0]           pend_reg;
    logic [NAW-1:0]           pend_next;
    logic                     pend_valid_reg;
    logic                     pend_valid_next;
    logic                     done_reg;
    logic                     done_next;
    result_t                  result_reg;
    result_t                  result_next;

    logic [NAW-1:0]           head_node;
    logic [LAW-1:0]           head_link;
    logic [LAW-1:0]           item_link;
    logic [SW-1:0]            cur_ext;
    logic [SW-1:0]            amt_ext;
    logic [SW-1:0]            sum_ext;
    logic [SW-1:0]            diff_ext;
    logic                     overflow;
    logic                     negative;
    logic                     match;
    logic                     scan_final;

    assign head_node = q_head.node_index[NAW-1:0];
    assign head_link = LAW'(q_head.link_index);
    assign item_link = LAW'(item_reg.link_index);

    // Traffic arithmetic on the registered memory word; unwritten links read zero
    assign cur_ext  = lvalid_reg[item_link] ? SW'(rdata_reg) : '0;
    assign amt_ext  = SW'(item_reg.traffic_amount);
    assign sum_ext  = cur_ext + amt_ext;
    assign diff_ext = cur_ext - amt_ext;
    assign overflow = sum_ext > TMAX;
    assign negative = amt_ext > cur_ext;

    assign match      = busy_map_reg[scan_reg] == (item_reg.op == OP_LIST_USED);
    assign scan_final = FC_W'(scan_reg) == (eff_nodes - 1'b1);

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next      = state_reg;
        busy_map_next   = busy_map_reg;
        free_next       = free_reg;
        lvalid_next     = lvalid_reg;
        item_next       = item_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = sum_ext[TRAFFIC_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    result_next.status       = STAT_OK;
                    result_next.free_count   = free_reg;
                    result_next.listed_node  = '0;
                    result_next.listed_valid = 1'b0;
                    result_next.link_total   = '0;
                    result_next.last         = 1'b1;
                    done_next = 1'b1;
                    case (q_head.op)
                        OP_CLAIM:
                        begin
                            if (busy_map_reg[head_node])
                            begin
                                result_next.status = STAT_NODE_BUSY;
                            end
                            else
                            begin
                                busy_map_next[head_node] = 1'b1;
                                free_next                = free_reg - 1'b1;
                                result_next.free_count   = free_reg - 1'b1;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (!busy_map_reg[head_node])
                            begin
                                result_next.status = STAT_NODE_IDLE;
                            end
                            else
                            begin
                                busy_map_next[head_node] = 1'b0;
                                free_next                = free_reg + 1'b1;
                                result_next.free_count   = free_reg + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB:
                        begin
                            done_next  = 1'b0;
                            state_next = ST_TRAFFIC;
                        end
                        OP_LIST_FREE, OP_LIST_USED:
                        begin
                            done_next       = 1'b0;
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_LIST;
                        end
                        OP_CLEAR:
                        begin
                            busy_map_next          = '0;
                            lvalid_next            = '0;
                            free_next              = eff_nodes;
                            result_next.free_count = eff_nodes;
                        end
                        default:
                        begin
                            result_next.status = STAT_BAD_INDEX;
                        end
                    endcase
                end
            end

            ST_TRAFFIC:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if ((item_reg.op == OP_ADD) ? overflow : negative)
                begin
                    result_next.status     = (item_reg.op == OP_ADD) ? STAT_OVERFLOW
                                                                     : STAT_NEGATIVE;
                    result_next.link_total = cur_ext[TOTAL_W-1:0];
                end
                else
                begin
                    mem_we                 = 1'b1;
                    mem_wdata              = (item_reg.op == OP_ADD)
                                             ? sum_ext[TRAFFIC_BITS-1:0]
                                             : diff_ext[TRAFFIC_BITS-1:0];
                    lvalid_next[item_link] = 1'b1;
                    result_next.link_total = (item_reg.op == OP_ADD)
                                             ? sum_ext[TOTAL_W-1:0]
                                             : diff_ext[TOTAL_W-1:0];
                end
            end

            ST_LIST:
            begin
                // Hold one match back so the final one can carry last
                if (match && pend_valid_reg)
                begin
                    done_next                = 1'b1;
                    result_next.listed_node  = NODE_W'(pend_reg);
                    result_next.listed_valid = 1'b1;
                    result_next.last         = 1'b0;
                end
                if (match)
                begin
                    pend_next       = scan_reg;
                    pend_valid_next = 1'b1;
                end
                if (scan_final)
                begin
                    state_next = ST_LIST_END;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_LIST_END:
            begin
                done_next                = 1'b1;
                result_next.listed_node  = pend_valid_reg ? NODE_W'(pend_reg) : '0;
                result_next.listed_valid = pend_valid_reg;
                result_next.last         = 1'b1;
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            busy_map_next = '0;
            lvalid_next   = '0;
            free_next     = clear_nodes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_map_reg   <= '0;
            free_reg       <= FC_W'(MAX_NODES);
            lvalid_reg     <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_map_reg   <= busy_map_next;
            free_reg       <= free_next;
            lvalid_reg     <= lvalid_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        scan_reg   <= scan_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            traffic_mem[item_link] <= mem_wdata;
        end
        rdata_reg <= traffic_mem[head_link];
    end

endmodule

// ----- hw/rtl/node_allocation_map_core.sv -----
// An accepted item enters the queue; the back end pops it when idle and registers its result.
// Traffic items first take one registered read of the traffic memory. A list walks every
// configured node in turn and gives one result per listed node (or one empty result), the
// final one marked last. A two-entry queue lets the front end take items while the back end
// works. Results cannot be stalled.
// Reset: all nodes free, every link total zero, node count MAX_NODES, link count MAX_LINKS clamped to 256.
module node_allocation_map_core
    import nam_pkg::*;
#(
    parameter int MAX_NODES    = 64,
    parameter int MAX_LINKS    = 256,
    parameter int TRAFFIC_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Link count register is wide enough for both the write data and MAX_LINKS
    localparam int LCW_RAW   = $clog2(MAX_LINKS + 1);
    localparam int LCW       = (LCW_RAW > CFG_W) ? LCW_RAW : CFG_W;
    localparam int LINKS_RST = (MAX_LINKS < 256) ? MAX_LINKS : 256;

    // Effective (clamped) sizes
    logic [FC_W-1:0] eff_nodes_reg;
    logic [FC_W-1:0] eff_nodes_next;
    logic [LCW-1:0]  eff_links_reg;
    logic [LCW-1:0]  eff_links_next;
    logic [FC_W-1:0] nodes_wr;
    logic [LCW-1:0]  links_wr;
    logic [FC_W-1:0] clear_nodes;

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    queue_entry_t    q_in;
    queue_entry_t    q_head;

    // Clamp writes into range so the rest of the block sees legal sizes only
    always_comb
    begin
        nodes_wr = cfg_data[FC_W-1:0];
        if (nodes_wr == '0)
        begin
            nodes_wr = FC_W'(1);
        end
        else if (nodes_wr > FC_W'(MAX_NODES))
        begin
            nodes_wr = FC_W'(MAX_NODES);
        end

        links_wr = LCW'(cfg_data);
        if (links_wr == '0)
        begin
            links_wr = LCW'(1);
        end
        else if (links_wr > LCW'(MAX_LINKS))
        begin
            links_wr = LCW'(MAX_LINKS);
        end

        eff_nodes_next = eff_nodes_reg;
        eff_links_next = eff_links_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODES: eff_nodes_next = nodes_wr;
                CFG_LINKS: eff_links_next = links_wr;
                default:   eff_nodes_next = eff_nodes_reg;
            endcase
        end
    end

    // A register write also frees all nodes and zeroes all link totals, free count set to the new node count
    assign clear_nodes = eff_nodes_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_nodes_reg <= FC_W'(MAX_NODES);
            eff_links_reg <= LCW'(LINKS_RST);
        end
        else
        begin
            eff_nodes_reg <= eff_nodes_next;
            eff_links_reg <= eff_links_next;
        end
    end

    // Front end: accept and classify each item
    nam_front #(
        .LINK_CNT_W (LCW)
    ) u_front (
        .start      (start),
        .cmd        (cmd),
        .eff_nodes  (eff_nodes_reg),
        .eff_links  (eff_links_reg),
        .q_full     (q_full),
        .busy       (busy),
        .push       (q_push),
        .entry      (q_in)
    );

    // Hold classified items until the back end is free
    nam_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .din        (q_in),
        .pop        (q_pop),
        .dout       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Back end: update the node map and link totals, walk the map for lists
    nam_back #(
        .MAX_NODES    (MAX_NODES),
        .MAX_LINKS    (MAX_LINKS),
        .TRAFFIC_BITS (TRAFFIC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .eff_nodes    (eff_nodes_reg),
        .cfg_clear    (cfg_we),
        .clear_nodes  (clear_nodes),
        .done         (done),
        .result       (result)
    );

    // A result that is not the last of its item always names a node
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> result.listed_valid)
    else $error("non-final result without a listed node");

    // A failed check always ends its item in a single result
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_OK) |-> result.last)
    else $error("error status on a non-final result");

    // Listed nodes only come from list items, which never fail
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.listed_valid) |-> (result.status == STAT_OK && result.link_total == '0))
    else $error("listed node carries a status or a link total");

    // The free count never exceeds the configured node count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(cfg_we)) |-> (result.free_count <= eff_nodes_reg))
    else $error("free count above node count");

endmodule
